// ===== src/jse_pkg.sv =====
// ============================================================================
// jse_pkg
// Shared types, constants and helper functions of the JSON string escaper.
// ============================================================================
`default_nettype none

package jse_pkg;

    localparam int MAX_UTF8_LEN = 4;
    localparam int MAX_RESULTS  = 9;
    localparam int GROUP_MAX    = 6;
    localparam int COUNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int PADDR_W      = 3;

    localparam logic [15:0] CAP_RESET = 16'd256;
    localparam logic [0:0]  REG_OUT_CAPACITY = 1'b0;

    localparam logic [1:0] ST_DATA     = 2'd0;
    localparam logic [1:0] ST_DONE     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
    } res_t;

    typedef struct packed {
        logic [COUNT_W-1:0]         count;
        res_t [MAX_RESULTS-1:0]     ent;
    } burst_t;

    // second byte of a short escape, zero when the byte has none
    function automatic logic [7:0] esc_second(input logic [7:0] c);
        logic [7:0] r;
        r = 8'h00;
        case (c)
            8'h22:   r = 8'h22;
            8'h5C:   r = 8'h5C;
            8'h08:   r = 8'h62;
            8'h0C:   r = 8'h66;
            8'h0A:   r = 8'h6E;
            8'h0D:   r = 8'h72;
            8'h09:   r = 8'h74;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
    endfunction

    // length of a UTF-8 pattern started by c, zero when c is no lead byte
    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] r;
        r = 3'd0;
        if ((c & 8'hE0) == 8'hC0) begin
            r = 3'd2;
        end else if ((c & 8'hF0) == 8'hE0) begin
            r = 3'd3;
        end else if ((c & 8'hF8) == 8'hF0) begin
            r = 3'd4;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/jse_apb_regs.sv =====
// ============================================================================
// jse_apb_regs
// APB register file holding the output buffer capacity.
// ============================================================================
`default_nettype none

module jse_apb_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [jse_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output logic      [15:0]                 cap
);

    logic [15:0] cap_reg;
    logic        hit;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == jse_pkg::REG_OUT_CAPACITY);
    assign cap    = cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= jse_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && pready && hit) begin
            cap_reg <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = 32'h0;
        if (hit) begin
            prdata = {16'h0, cap_reg};
        end
    end

endmodule

`default_nettype wire

// ===== src/jse_escape.sv =====
// ============================================================================
// jse_escape
// Escape logic and string state: turns one request into a burst of results.
// ============================================================================
`default_nettype none

module jse_escape (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire jse_pkg::in_item_t item,
    input  wire logic [15:0]       cap,
    output jse_pkg::burst_t        burst
);

    logic [15:0] wc_reg, wc_next;
    logic [2:0]  hc_reg, hc_next;
    logic [2:0]  el_reg, el_next;
    logic        err_reg, err_next;
    logic [7:0]  held_reg  [jse_pkg::MAX_UTF8_LEN];
    logic [7:0]  held_next [jse_pkg::MAX_UTF8_LEN];

    logic        avail_ok;
    logic [15:0] avail;
    logic        ok_v [jse_pkg::MAX_RESULTS+1];
    logic [2:0]  fit;
    logic [7:0]  c;
    logic        is_cont;
    logic [7:0]  second;
    logic [2:0]  llen;
    logic [2:0]  glen;
    jse_pkg::res_t gbytes [jse_pkg::GROUP_MAX];
    jse_pkg::res_t tail   [jse_pkg::GROUP_MAX];
    logic [2:0]  pre_n;
    logic [2:0]  tail_n;
    logic [3:0]  need;
    logic [15:0] base;
    jse_pkg::res_t err_res;

    assign c        = item.in_byte;
    assign is_cont  = (c & 8'hC0) == 8'h80;
    assign avail_ok = cap > wc_reg;
    assign avail    = cap - wc_reg - 16'd1;
    assign err_res  = {8'h00, jse_pkg::ST_OVERFLOW};
    assign second   = jse_pkg::esc_second(c);
    assign llen     = jse_pkg::lead_len(c);

    always_comb begin
        for (int i = 0; i <= jse_pkg::MAX_RESULTS; i++) begin
            ok_v[i] = avail_ok && (avail >= 16'(i));
        end
        if (!avail_ok) begin
            fit = 3'd0;
        end else if (avail >= 16'(hc_reg)) begin
            fit = hc_reg;
        end else begin
            fit = avail[2:0];
        end
    end

    // escaped form of a byte that is not a lead byte
    always_comb begin
        for (int i = 0; i < jse_pkg::GROUP_MAX; i++) begin
            gbytes[i] = '0;
        end
        if (second != 8'h00) begin
            glen      = 3'd2;
            gbytes[0] = {8'h5C, jse_pkg::ST_DATA};
            gbytes[1] = {second, jse_pkg::ST_DATA};
        end else if (c < 8'h20) begin
            glen      = 3'd6;
            gbytes[0] = {8'h5C, jse_pkg::ST_DATA};
            gbytes[1] = {8'h75, jse_pkg::ST_DATA};
            gbytes[2] = {8'h30, jse_pkg::ST_DATA};
            gbytes[3] = {8'h30, jse_pkg::ST_DATA};
            gbytes[4] = {jse_pkg::hex_digit(c[7:4]), jse_pkg::ST_DATA};
            gbytes[5] = {jse_pkg::hex_digit(c[3:0]), jse_pkg::ST_DATA};
        end else begin
            glen      = 3'd1;
            gbytes[0] = {c, jse_pkg::ST_DATA};
        end
    end

    always_comb begin
        wc_next  = wc_reg;
        hc_next  = hc_reg;
        el_next  = el_reg;
        err_next = err_reg;
        for (int i = 0; i < jse_pkg::MAX_UTF8_LEN; i++) begin
            held_next[i] = held_reg[i];
        end
        for (int i = 0; i < jse_pkg::GROUP_MAX; i++) begin
            tail[i] = '0;
        end
        pre_n  = 3'd0;
        tail_n = 3'd0;
        need   = 4'd0;
        base   = wc_reg;

        if (item.end_of_string) begin
            tail_n = 3'd1;
            if (err_reg) begin
                tail[0] = err_res;
            end else begin
                pre_n   = fit;
                tail[0] = ok_v[hc_reg] ? {8'h00, jse_pkg::ST_DONE} : err_res;
            end
            wc_next  = 16'd0;
            hc_next  = 3'd0;
            el_next  = 3'd0;
            err_next = 1'b0;
        end else if (!err_reg) begin
            if (hc_reg != 3'd0 && is_cont) begin
                need = 4'(hc_reg) + 4'd1;
                if (need >= 4'(el_reg)) begin
                    hc_next = 3'd0;
                    el_next = 3'd0;
                    tail_n  = 3'd1;
                    if (ok_v[need]) begin
                        pre_n   = hc_reg;
                        tail[0] = {c, jse_pkg::ST_DATA};
                        wc_next = wc_reg + 16'(need);
                    end else begin
                        tail[0]  = err_res;
                        err_next = 1'b1;
                    end
                end else begin
                    held_next[hc_reg[1:0]] = c;
                    hc_next = hc_reg + 3'd1;
                end
            end else if (fit != hc_reg) begin
                // held bytes do not all fit
                pre_n    = fit;
                tail[0]  = err_res;
                tail_n   = 3'd1;
                err_next = 1'b1;
                hc_next  = 3'd0;
                el_next  = 3'd0;
                wc_next  = wc_reg + 16'(fit);
            end else begin
                pre_n   = hc_reg;
                hc_next = 3'd0;
                el_next = 3'd0;
                base    = wc_reg + 16'(hc_reg);
                wc_next = base;
                if (second == 8'h00 && c >= 8'h20 && llen != 3'd0) begin
                    held_next[0] = c;
                    hc_next      = 3'd1;
                    el_next      = llen;
                end else begin
                    need = 4'(hc_reg) + 4'(glen);
                    if (ok_v[need]) begin
                        for (int i = 0; i < jse_pkg::GROUP_MAX; i++) begin
                            tail[i] = gbytes[i];
                        end
                        tail_n  = glen;
                        wc_next = base + 16'(glen);
                    end else begin
                        tail[0]  = err_res;
                        tail_n   = 3'd1;
                        err_next = 1'b1;
                    end
                end
            end
        end
    end

    // held bytes first, then the tail group
    always_comb begin
        logic [3:0] j;
        j = 4'd0;
        burst.count = jse_pkg::COUNT_W'(4'(pre_n) + 4'(tail_n));
        for (int p = 0; p < jse_pkg::MAX_RESULTS; p++) begin
            burst.ent[p] = '0;
            j = 4'(p) - 4'(pre_n);
            if (4'(p) < 4'(pre_n)) begin
                burst.ent[p] = {held_reg[2'(p)], jse_pkg::ST_DATA};
            end else if (j < 4'(jse_pkg::GROUP_MAX)) begin
                burst.ent[p] = tail[j[2:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg  <= 16'd0;
            hc_reg  <= 3'd0;
            el_reg  <= 3'd0;
            err_reg <= 1'b0;
        end else if (accept) begin
            wc_reg  <= wc_next;
            hc_reg  <= hc_next;
            el_reg  <= el_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < jse_pkg::MAX_UTF8_LEN; i++) begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    a_held_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        hc_reg < 3'(jse_pkg::MAX_UTF8_LEN))
        else $error("held count reached a full sequence without release");

    a_held_short: assert property (@(posedge aclk) disable iff (!aresetn)
        hc_reg != 3'd0 |-> el_reg > hc_reg)
        else $error("held count not below expected length");

    a_err_no_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> hc_reg == 3'd0)
        else $error("bytes held while error latched");

    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && item.end_of_string |=> wc_reg == 16'd0 && !err_reg)
        else $error("terminator did not clear string state");

endmodule

`default_nettype wire

// ===== src/jse_emit.sv =====
// ============================================================================
// jse_emit
// Result buffer: holds one burst, gives one result per cycle while m_ready.
// ============================================================================
`default_nettype none

module jse_emit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            load,
    input  wire jse_pkg::burst_t burst,
    output logic                 can_load,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output jse_pkg::out_item_t   m_data
);

    logic [jse_pkg::COUNT_W-1:0]  cnt_reg;
    logic [jse_pkg::COUNT_W-1:0]  idx_reg;
    jse_pkg::res_t [jse_pkg::MAX_RESULTS-1:0] ent_reg;
    logic                         last;

    assign m_valid  = idx_reg != cnt_reg;
    assign last     = idx_reg == (cnt_reg - jse_pkg::COUNT_W'(1));
    assign can_load = !m_valid || (last && m_ready);

    always_comb begin
        m_data = '0;
        if (m_valid) begin
            m_data.out_byte = ent_reg[idx_reg].out_byte;
            m_data.status   = ent_reg[idx_reg].status;
            m_data.run_last = last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            cnt_reg <= burst.count;
            idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            idx_reg <= idx_reg + jse_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ent_reg <= burst.ent;
        end
    end

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= cnt_reg && cnt_reg <= jse_pkg::COUNT_W'(jse_pkg::MAX_RESULTS))
        else $error("result index beyond burst");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> can_load)
        else $error("burst loaded over pending results");

    a_last_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && last && !load |=> !m_valid)
        else $error("burst did not end after last result");

endmodule

`default_nettype wire

// ===== src/json_string_escaper.sv =====
// ============================================================================
// json_string_escaper
// Streaming JSON string escaper with capacity check and UTF-8 grouping.
// ============================================================================
// Latency: the first result of a request appears the cycle after it is taken.
// Throughput: one request per cycle while each gives at most one result and
//   m_ready is high; one giving more (up to 9) holds s_ready low while the
//   result buffer drains them, one result per cycle while m_ready is high.
// Reset: clears the written count, held-byte count and error; capacity goes to 256.
`default_nettype none

module json_string_escaper (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire jse_pkg::in_item_t           s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output jse_pkg::out_item_t               m_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [jse_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    logic            accept;
    logic            can_load;
    logic [15:0]     cap;
    jse_pkg::burst_t burst;

    assign s_ready = can_load;
    assign accept  = s_valid && s_ready;

    jse_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cap     (cap)
    );

    jse_escape u_escape (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .cap     (cap),
        .burst   (burst)
    );

    jse_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .burst    (burst),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ============================================================================
// tb_top
// Testbench for json_string_escaper: strings go in one byte per request, and
// each result is checked against a scoreboard that predicts escapes, UTF-8
// grouping, capacity overflow and terminators. Both sides idle at random.
// ============================================================================

module tb_top;

    localparam logic [jse_pkg::PADDR_W-1:0] CAP_ADDR = {jse_pkg::REG_OUT_CAPACITY, 2'b00};

    // ------------------------------------------------------------------------
    class escape_scoreboard;
        logic [15:0]        capacity;
        logic [15:0]        written;
        logic [7:0]         held [jse_pkg::MAX_UTF8_LEN];
        int                 held_n;
        int                 want_len;
        bit                 err_latched;
        jse_pkg::out_item_t expected_q [$];
        jse_pkg::out_item_t burst [$];
        int                 errors;

        function new();
            capacity    = jse_pkg::CAP_RESET;
            written     = '0;
            held_n      = 0;
            want_len    = 0;
            err_latched = 1'b0;
            errors      = 0;
        endfunction

        function void set_capacity(logic [15:0] v);
            capacity = v;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        function bit room(int unsigned n);
            if (capacity == 0 || written >= capacity) return 1'b0;
            return n <= int'(capacity) - int'(written) - 1;
        endfunction

        function void emit(logic [7:0] b, logic [1:0] st);
            jse_pkg::out_item_t r;
            r.out_byte = b;
            r.status   = st;
            r.run_last = 1'b0;
            burst.push_back(r);
        endfunction

        function void overflow();
            emit(8'h00, jse_pkg::ST_OVERFLOW);
            err_latched = 1'b1;
            held_n      = 0;
            want_len    = 0;
        endfunction

        function bit copy_byte(logic [7:0] b);
            if (!room(1)) begin
                overflow();
                return 1'b0;
            end
            emit(b, jse_pkg::ST_DATA);
            written = written + 16'd1;
            return 1'b1;
        endfunction

        function bit spill_held();
            int cnt;
            cnt      = held_n;
            held_n   = 0;
            want_len = 0;
            for (int k = 0; k < cnt; k++) begin
                if (!copy_byte(held[k])) return 1'b0;
            end
            return 1'b1;
        endfunction

        function logic [7:0] nibble_char(logic [3:0] v);
            return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v) - 8'd10;
        endfunction

        function void encode_byte(logic [7:0] c);
            logic [7:0] second;
            int         n;
            case (c)
                8'h22:   second = 8'h22;
                8'h5C:   second = 8'h5C;
                8'h08:   second = 8'h62;
                8'h0C:   second = 8'h66;
                8'h0A:   second = 8'h6E;
                8'h0D:   second = 8'h72;
                8'h09:   second = 8'h74;
                default: second = 8'h00;
            endcase
            if (second != 8'h00) begin
                if (!room(2)) begin
                    overflow();
                    return;
                end
                emit(8'h5C, jse_pkg::ST_DATA);
                emit(second, jse_pkg::ST_DATA);
                written = written + 16'd2;
                return;
            end
            if (c < 8'h20) begin
                if (!room(6)) begin
                    overflow();
                    return;
                end
                emit(8'h5C, jse_pkg::ST_DATA);
                emit(8'h75, jse_pkg::ST_DATA);
                emit(8'h30, jse_pkg::ST_DATA);
                emit(8'h30, jse_pkg::ST_DATA);
                emit(nibble_char(c[7:4]), jse_pkg::ST_DATA);
                emit(nibble_char(c[3:0]), jse_pkg::ST_DATA);
                written = written + 16'd6;
                return;
            end
            if (c[7:5] == 3'b110) n = 2;
            else if (c[7:4] == 4'b1110) n = 3;
            else if (c[7:3] == 5'b11110) n = 4;
            else n = 1;
            if (n > 1) begin
                held[0]  = c;
                held_n   = 1;
                want_len = n;
                return;
            end
            void'(copy_byte(c));
        endfunction

        // returns 1 when the request is dropped without effect
        function bit note_request(jse_pkg::in_item_t it);
            bit dropped;
            dropped = err_latched && !it.end_of_string;
            burst.delete();
            if (it.end_of_string) begin
                if (err_latched) begin
                    emit(8'h00, jse_pkg::ST_OVERFLOW);
                end else if (spill_held()) begin
                    if (capacity == 0 || written >= capacity)
                        emit(8'h00, jse_pkg::ST_OVERFLOW);
                    else
                        emit(8'h00, jse_pkg::ST_DONE);
                end
                written     = '0;
                held_n      = 0;
                want_len    = 0;
                err_latched = 1'b0;
            end else if (!err_latched) begin
                if (held_n > 0) begin
                    if (it.in_byte[7:6] == 2'b10 && held_n < jse_pkg::MAX_UTF8_LEN) begin
                        held[held_n] = it.in_byte;
                        held_n++;
                        if (held_n >= want_len) begin
                            if (!room(held_n)) begin
                                overflow();
                            end else begin
                                for (int k = 0; k < held_n; k++)
                                    emit(held[k], jse_pkg::ST_DATA);
                                written  = written + 16'(held_n);
                                held_n   = 0;
                                want_len = 0;
                            end
                        end
                    end else if (spill_held()) begin
                        encode_byte(it.in_byte);
                    end
                end else begin
                    encode_byte(it.in_byte);
                end
            end
            if (burst.size() > 0) burst[burst.size()-1].run_last = 1'b1;
            foreach (burst[k]) expected_q.push_back(burst[k]);
            return dropped;
        endfunction

        task check_result(jse_pkg::out_item_t got);
            jse_pkg::out_item_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result byte=%h status=%0d last=%0d",
                                 got.out_byte, got.status, got.run_last));
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.run_last !== want.run_last)
                report($sformatf("run_last %0d, want %0d", got.run_last, want.run_last));
        endtask

        task check_leftover();
            if (expected_q.size() != 0)
                report($sformatf("%0d results never arrived", expected_q.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    jse_pkg::in_item_t            s_data;
    logic                         m_valid;
    logic                         m_ready;
    jse_pkg::out_item_t           m_data;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [jse_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    escape_scoreboard sb = new();
    int               src_mode;
    int               rx_hold_req;
    int               live_items;

    json_string_escaper dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int draw_gap(int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 18);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    task automatic push_request(jse_pkg::in_item_t it);
        int gap;
        gap = draw_gap(src_mode);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
        void'(sb.note_request(it));
        live_items++;
    endtask

    task automatic send_byte(logic [7:0] b);
        jse_pkg::in_item_t it;
        it.in_byte       = b;
        it.end_of_string = 1'b0;
        push_request(it);
    endtask

    task automatic send_end();
        jse_pkg::in_item_t it;
        it.in_byte       = 8'($urandom_range(0, 255));
        it.end_of_string = 1'b1;
        push_request(it);
    endtask

    // sender holds off until every expected result has drained
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.expected_q.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= {16'h0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_capacity(v);
    endtask

    function automatic logic [7:0] short_escape_char(int i);
        case (i)
            0:       return 8'h22;
            1:       return 8'h5C;
            2:       return 8'h08;
            3:       return 8'h0C;
            4:       return 8'h0A;
            5:       return 8'h0D;
            default: return 8'h09;
        endcase
    endfunction

    function automatic logic [7:0] lead_of(int n);
        case (n)
            2:       return {3'b110, 5'($urandom_range(0, 31))};
            3:       return {4'b1110, 4'($urandom_range(0, 15))};
            default: return {5'b11110, 3'($urandom_range(0, 7))};
        endcase
    endfunction

    task automatic random_string();
        int len;
        int n;
        len      = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
        src_mode = $urandom_range(0, 2);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3: send_byte(8'($urandom_range(8'h20, 8'h7E)));
                4:          send_byte(short_escape_char($urandom_range(0, 6)));
                5:          send_byte(8'($urandom_range(0, 8'h1F)));
                6, 7, 8: begin
                    n = $urandom_range(2, 4);
                    send_byte(lead_of(n));
                    repeat (n - 1) send_byte({2'b10, 6'($urandom_range(0, 63))});
                end
                9:          send_byte(8'($urandom_range(0, 255)));
                10: begin
                    // truncated sequence
                    n = $urandom_range(2, 4);
                    send_byte(lead_of(n));
                    repeat ($urandom_range(0, n - 2))
                        send_byte({2'b10, 6'($urandom_range(0, 63))});
                end
                default:    send_byte({2'b10, 6'($urandom_range(0, 63))});
            endcase
        end
        send_end();
    endtask

    function automatic logic [15:0] pick_capacity(int phase);
        case (phase)
            0:       return 16'hFFFF;
            1:       return 16'd0;
            2:       return 16'd1;
            3:       return 16'd7;
            default: begin
                if ($urandom_range(0, 7) == 0) return 16'($urandom_range(0, 65535));
                return 16'($urandom_range(2, 200));
            end
        endcase
    endfunction

    // result side
    initial begin
        int gap;
        int rx_mode;
        int hold;
        m_ready <= 1'b0;
        rx_mode = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_hold_req > 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            if ($urandom_range(0, 24) == 0) rx_mode = $urandom_range(0, 2);
            gap = draw_gap(rx_mode);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            sb.check_result(m_data);
        end
    end

    // request side
    initial begin
        logic [7:0] text_a [$];
        int  phase;
        int  next_cfg;
        bit  filled;
        bit  paused;
        int  w;
        text_a = '{8'h22, 8'h5C, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h1F,
                   8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F,
                   8'h98, 8'h80, 8'hC3, 8'h41, 8'hFF, 8'h80};
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        src_mode    = 0;
        rx_hold_req = 0;
        live_items  = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // escapes, UTF-8 groups, broken lead, high bytes, stray continuation
        foreach (text_a[k]) send_byte(text_a[k]);
        send_end();
        // terminator while a sequence is held
        send_byte(8'hE2);
        send_byte(8'h82);
        send_end();
        settle();
        // overflow on a control escape, later bytes dropped
        write_capacity(16'd5);
        send_byte(8'h41);
        send_byte(8'h01);
        send_byte(8'h42);
        send_end();
        settle();
        write_capacity(16'd0);
        send_end();
        settle();
        // capacity lowered below the count mid-string
        write_capacity(16'd256);
        send_byte(8'h41);
        send_byte(8'h42);
        send_byte(8'h43);
        settle();
        write_capacity(16'd2);
        send_end();
        settle();

        live_items = 0;
        next_cfg   = 0;
        phase      = 0;
        filled     = 1'b0;
        paused     = 1'b0;
        while (live_items < 430) begin
            if (live_items >= next_cfg) begin
                settle();
                write_capacity(pick_capacity(phase));
                phase++;
                next_cfg = live_items + $urandom_range(30, 60);
            end
            if (!filled && live_items > 150) begin
                // long receiver stall while requests keep coming
                settle();
                write_capacity(16'hFFFF);
                rx_hold_req = 300;
                src_mode    = 0;
                repeat (30) send_byte(8'($urandom_range(0, 8'h1F)));
                send_end();
                filled = 1'b1;
            end
            if (!paused && live_items > 280) begin
                settle();
                paused = 1'b1;
            end
            random_string();
        end

        s_valid <= 1'b0;
        for (w = 0; w < 200000 && sb.expected_q.size() > 0; w++) @(posedge aclk);
        repeat (20) @(posedge aclk);
        sb.check_leftover();
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #12000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/jse_pkg.sv
src/jse_apb_regs.sv
src/jse_escape.sv
src/jse_emit.sv
src/json_string_escaper.sv
verif/tb_top.sv
